>>> hw/rtl/grb_pkg.sv
// Shared constants, register codes and helpers for the glyph row blitter.
`default_nettype none

package grb_pkg;

	// default design limits
	localparam int MAX_GLYPH_HEIGHT_DEF = 16;
	localparam int MAX_SCALE_DEF        = 4;

	// font store geometry
	localparam int FONT_AW    = 12;
	localparam int FONT_DEPTH = 1 << FONT_AW;
	localparam int FONT_W     = 8;

	// fixed field widths
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int GHREG_W = 5;
	localparam int CODE_W  = 8;
	localparam int SCIN_W  = 3;
	localparam int COLOR_W = 32;
	localparam int RADDR_W = 24;
	localparam int MASK_W  = 32;
	localparam int DWOUT_W = 6;

	// configuration port
	localparam int CFG_IW = 3;
	localparam int CFG_DW = 13;

	typedef enum logic [CFG_IW-1:0] {
		CFG_ENABLED       = 3'd0,
		CFG_SCREEN_WIDTH  = 3'd1,
		CFG_SCREEN_HEIGHT = 3'd2,
		CFG_ROW_STRIDE    = 3'd3,
		CFG_GLYPH_HEIGHT  = 3'd4,
		CFG_SWAP_RED_BLUE = 3'd5
	} cfg_reg_t;

	// register reset values
	localparam logic               RST_ENABLED       = 1'b1;
	localparam logic [DIM_W-1:0]   RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [DIM_W-1:0]   RST_SCREEN_HEIGHT = 13'd480;
	localparam logic [DIM_W-1:0]   RST_ROW_STRIDE    = 13'd640;
	localparam logic [GHREG_W-1:0] RST_GLYPH_HEIGHT  = 5'd8;
	localparam logic               RST_SWAP_RED_BLUE = 1'b0;

	localparam logic              OP_LOAD = 1'b0;
	localparam logic              OP_BLIT = 1'b1;

	localparam logic [COLOR_W-1:0] KEEP_MASK = 32'hFF00_FF00;

	// 0x00RRGGBB <-> 0x00BBGGRR
	function automatic logic [COLOR_W-1:0] swap_rb(input logic [COLOR_W-1:0] c);
		logic [COLOR_W-1:0] res;
		res = (c & KEEP_MASK) | {8'h00, c[7:0], 8'h00, c[23:16]};
		return res;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/grb_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module grb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/grb_row_expand.sv
// Widens one glyph row by the scale factor and clips it to the drawn width.
`default_nettype none

module grb_row_expand
	import grb_pkg::*;
#(
	parameter int MAX_SCALE = MAX_SCALE_DEF,
	parameter int SC_W      = $clog2(MAX_SCALE + 1),
	parameter int CW_W      = SC_W + 3
) (
	input  wire logic [FONT_W-1:0] bits,
	input  wire logic [SC_W-1:0]   sc,
	input  wire logic [CW_W-1:0]   dw,
	output      logic [MASK_W-1:0] mask
);

	logic [MASK_W-1:0] exp_mask [1:MAX_SCALE];
	logic [MASK_W-1:0] sel_mask;

	// pixel p of a scale-s row shows glyph column p/s
	for (genvar s = 1; s <= MAX_SCALE; s++) begin : g_scale
		for (genvar p = 0; p < MASK_W; p++) begin : g_pix
			localparam int GX = p / s;
			if (GX < FONT_W) begin : g_in
				assign exp_mask[s][p] = bits[FONT_W-1-GX];
			end else begin : g_out
				assign exp_mask[s][p] = 1'b0;
			end
		end
	end

	always_comb begin
		sel_mask = '0;
		for (int s = 1; s <= MAX_SCALE; s++) begin
			if (sc == SC_W'(s)) begin
				sel_mask = exp_mask[s];
			end
		end
		for (int p = 0; p < MASK_W; p++) begin
			mask[p] = sel_mask[p] & (32'(dw) > 32'(p));
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/glyph_row_blitter_core.sv
// Top level of the glyph row blitter: request decode, setup, row sequencer, output register.
`default_nettype none

// A load request writes one byte into the 4096 x 8 font RAM. A blit request
// is accepted while idle, then passes through a setup state (glyph base,
// row count and first framebuffer address products) and a clip state and
// issues one font RAM read per output row; the input stays stalled until the
// last row of the blit has left the read stage. The single read port of the
// font RAM sets the one-row-per-cycle pace; a stalled output holds the row
// sequencer through the read stage, with no rows dropped. Blits that are
// disabled, have a zero glyph height or start off screen give no rows and
// free the input after the clip state. The font RAM has no reset: glyphs
// must be loaded before they are drawn. Configuration writes are always
// accepted (cfg_ready is tied high) and must only be issued while idle.
module glyph_row_blitter_core
	import grb_pkg::*;
#(
	parameter int MAX_GLYPH_HEIGHT = MAX_GLYPH_HEIGHT_DEF,
	parameter int MAX_SCALE        = MAX_SCALE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [CFG_IW-1:0]    cfg_index,
	input  wire logic [CFG_DW-1:0]    cfg_data,
	// request channel
	input  wire logic                 in_valid,
	output      logic                 in_stall,
	input  wire logic                 opcode,
	input  wire logic [FONT_AW-1:0]   font_address,
	input  wire logic [FONT_W-1:0]    font_byte,
	input  wire logic [CODE_W-1:0]    glyph_code,
	input  wire logic [COORD_W-1:0]   x_pos,
	input  wire logic [COORD_W-1:0]   y_pos,
	input  wire logic [SCIN_W-1:0]    scale,
	input  wire logic [COLOR_W-1:0]   fg_rgb,
	input  wire logic [COLOR_W-1:0]   bg_rgb,
	// row result channel
	output      logic                 out_valid,
	input  wire logic                 out_stall,
	output      logic [RADDR_W-1:0]   row_address,
	output      logic [MASK_W-1:0]    pixel_mask,
	output      logic [DWOUT_W-1:0]   draw_width,
	output      logic [COLOR_W-1:0]   fg_out,
	output      logic [COLOR_W-1:0]   bg_out,
	output      logic                 last
);

	localparam int SC_W = $clog2(MAX_SCALE + 1);
	localparam int GH_W = $clog2(MAX_GLYPH_HEIGHT + 1);
	localparam int CW_W = SC_W + 3;
	localparam int DH_W = $clog2(MAX_GLYPH_HEIGHT * MAX_SCALE + 1);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SETUP = 4'b0010,
		ST_CLIP  = 4'b0100,
		ST_RUN   = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic               enabled_q;
	logic [DIM_W-1:0]   screen_width_q;
	logic [DIM_W-1:0]   screen_height_q;
	logic [DIM_W-1:0]   row_stride_q;
	logic [GHREG_W-1:0] glyph_height_q;
	logic               swap_red_blue_q;

	// captured blit request
	logic [CODE_W-1:0]  ch_q;
	logic [COORD_W-1:0] x_q;
	logic [COORD_W-1:0] y_q;
	logic [SC_W-1:0]    sc_q;
	logic [COLOR_W-1:0] fg_q;
	logic [COLOR_W-1:0] bg_q;

	// setup results
	logic [FONT_AW-1:0] base_q;
	logic [DH_W-1:0]    dh_raw_q;
	logic [24:0]        addr_mul_q;
	logic               empty_q;

	// row sequencer
	logic [CW_W-1:0]    dw_q;
	logic [DH_W-1:0]    rows_left_q;
	logic [GH_W-1:0]    gr_q;
	logic [SC_W-1:0]    sr_q;
	logic [RADDR_W-1:0] row_addr_q;

	// read stage
	logic               valid_s1;
	logic [RADDR_W-1:0] addr_s1;
	logic               last_s1;

	// output register
	logic               out_valid_q;
	logic [RADDR_W-1:0] out_addr_q;
	logic [MASK_W-1:0]  out_mask_q;
	logic [DWOUT_W-1:0] out_dw_q;
	logic [COLOR_W-1:0] out_fg_q;
	logic [COLOR_W-1:0] out_bg_q;
	logic               out_last_q;

	logic               in_acc;
	logic               s1_move;
	logic               issue;
	logic [SC_W-1:0]    sc_d;
	logic [GH_W-1:0]    ch_h_d;
	logic [CW_W-1:0]    cw_d;
	logic [CODE_W+GH_W-1:0] base_prod;
	logic [GH_W+SC_W-1:0]   dh_prod;
	logic [FONT_AW-1:0] rd_addr;
	logic [FONT_W-1:0]  rd_bits;
	logic [MASK_W-1:0]  row_mask;
	logic [13:0]        x_end;
	logic [13:0]        y_end;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE) || valid_s1;
	assign in_acc    = in_valid && !in_stall;

	assign s1_move = valid_s1 && (!out_valid_q || !out_stall);
	assign issue   = (state_q == ST_RUN) && (!valid_s1 || s1_move);

	// scale 0 acts as 1, large scales saturate
	always_comb begin
		if (scale == '0) begin
			sc_d = SC_W'(1);
		end else if (32'(scale) > 32'(MAX_SCALE)) begin
			sc_d = SC_W'(MAX_SCALE);
		end else begin
			sc_d = SC_W'(scale);
		end
	end

	always_comb begin
		if (32'(glyph_height_q) > 32'(MAX_GLYPH_HEIGHT)) begin
			ch_h_d = GH_W'(MAX_GLYPH_HEIGHT);
		end else begin
			ch_h_d = GH_W'(glyph_height_q);
		end
	end

	assign cw_d      = {sc_q, 3'b000};
	assign base_prod = ch_q * ch_h_d;
	assign dh_prod   = ch_h_d * sc_q;
	assign x_end     = {2'b00, x_q} + 14'(cw_d);
	assign y_end     = {2'b00, y_q} + 14'(dh_raw_q);

	// glyph row address wraps inside the font store
	assign rd_addr = base_q + FONT_AW'(gr_q);

	grb_ram #(
		.WIDTH (FONT_W),
		.DEPTH (FONT_DEPTH)
	) u_font_ram (
		.clk   (clk),
		.we    (in_acc && (opcode == OP_LOAD)),
		.waddr (font_address),
		.wdata (font_byte),
		.re    (issue),
		.raddr (rd_addr),
		.rdata (rd_bits)
	);

	grb_row_expand #(
		.MAX_SCALE (MAX_SCALE),
		.SC_W      (SC_W),
		.CW_W      (CW_W)
	) u_row_expand (
		.bits (rd_bits),
		.sc   (sc_q),
		.dw   (dw_q),
		.mask (row_mask)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q       <= RST_ENABLED;
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
			row_stride_q    <= RST_ROW_STRIDE;
			glyph_height_q  <= RST_GLYPH_HEIGHT;
			swap_red_blue_q <= RST_SWAP_RED_BLUE;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ENABLED:       enabled_q       <= cfg_data[0];
				CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_data;
				CFG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				CFG_ROW_STRIDE:    row_stride_q    <= cfg_data;
				CFG_GLYPH_HEIGHT:  glyph_height_q  <= cfg_data[GHREG_W-1:0];
				CFG_SWAP_RED_BLUE: swap_red_blue_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// request capture, setup and clip (payload, no reset)
	always_ff @(posedge clk) begin
		if (in_acc && (opcode == OP_BLIT)) begin
			ch_q <= glyph_code;
			x_q  <= x_pos;
			y_q  <= y_pos;
			sc_q <= sc_d;
			fg_q <= swap_red_blue_q ? swap_rb(fg_rgb) : fg_rgb;
			bg_q <= swap_red_blue_q ? swap_rb(bg_rgb) : bg_rgb;
		end
		if (state_q == ST_SETUP) begin
			base_q     <= FONT_AW'(base_prod);
			dh_raw_q   <= DH_W'(dh_prod);
			addr_mul_q <= y_q * row_stride_q;
			empty_q    <= !enabled_q || (ch_h_d == '0) ||
			              ({1'b0, x_q} >= screen_width_q) ||
			              ({1'b0, y_q} >= screen_height_q);
		end
		if (state_q == ST_CLIP) begin
			// right and bottom edge clipping
			if (x_end > {1'b0, screen_width_q}) begin
				dw_q <= CW_W'(screen_width_q - {1'b0, x_q});
			end else begin
				dw_q <= cw_d;
			end
			if (y_end > {1'b0, screen_height_q}) begin
				rows_left_q <= DH_W'(screen_height_q - {1'b0, y_q});
			end else begin
				rows_left_q <= dh_raw_q;
			end
			row_addr_q <= RADDR_W'(addr_mul_q + 25'(x_q));
			gr_q       <= '0;
			sr_q       <= '0;
		end else if (issue) begin
			row_addr_q  <= row_addr_q + RADDR_W'(row_stride_q);
			rows_left_q <= rows_left_q - DH_W'(1);
			if (sr_q == sc_q - SC_W'(1)) begin
				sr_q <= '0;
				gr_q <= gr_q + GH_W'(1);
			end else begin
				sr_q <= sr_q + SC_W'(1);
			end
		end
		if (issue) begin
			addr_s1 <= row_addr_q;
			last_s1 <= (rows_left_q == DH_W'(1));
		end
		if (s1_move) begin
			out_addr_q <= addr_s1;
			out_mask_q <= row_mask;
			out_dw_q   <= DWOUT_W'(dw_q);
			out_fg_q   <= fg_q;
			out_bg_q   <= bg_q;
			out_last_q <= last_s1;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (opcode == OP_BLIT)) begin
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: state_q <= ST_CLIP;
				ST_CLIP: begin
					state_q <= empty_q ? ST_IDLE : ST_RUN;
				end
				ST_RUN: begin
					if (issue && (rows_left_q == DH_W'(1))) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase

			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (s1_move) begin
				valid_s1 <= 1'b0;
			end

			if (s1_move) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign row_address = out_addr_q;
	assign pixel_mask  = out_mask_q;
	assign draw_width  = out_dw_q;
	assign fg_out      = out_fg_q;
	assign bg_out      = out_bg_q;
	assign last        = out_last_q;

endmodule

`default_nettype wire
